// ===== hdl/bqf_pkg.sv =====
`timescale 1ns / 1ps

package bqf_pkg;

   // Fixed field widths and number formats.
   localparam int COEF_BITS      = 32;
   localparam int GAIN_BITS      = 16;
   localparam int CHCOUNT_BITS   = 4;
   localparam int STATE_BITS     = 48;
   localparam int Y_LOW_BITS     = 24;
   localparam int GUARD_BITS     = 8;
   localparam int GAIN_FRAC_BITS = 15;
   localparam int MIX_SHIFT      = GUARD_BITS + GAIN_FRAC_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int PC_BITS        = 4;

   localparam logic [GAIN_BITS-1:0]    WET_RESET     = 16'd32768;
   localparam logic [GAIN_BITS-1:0]    DRY_RESET     = 16'd0;
   localparam logic [CHCOUNT_BITS-1:0] CHCOUNT_RESET = 4'd1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COEF_B0  = 3'd0,
      REG_COEF_B1  = 3'd1,
      REG_COEF_B2  = 3'd2,
      REG_COEF_A1  = 3'd3,
      REG_COEF_A2  = 3'd4,
      REG_WET_GAIN = 3'd5,
      REG_DRY_GAIN = 3'd6,
      REG_CHANNELS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
      logic [GAIN_BITS-1:0]        wet;
      logic [GAIN_BITS-1:0]        dry;
      logic [CHCOUNT_BITS-1:0]     channels;
   } cfg_type;

   // Control word fields.
   typedef enum logic [2:0] {
      MA_B0, MA_B1, MA_B2, MA_A1, MA_A2, MA_WET, MA_DRY
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_X, MB_YH, MB_YL
   } mul_b_type;

   typedef enum logic [1:0] {
      BASE_ACC, BASE_Z1, BASE_Z2, BASE_ZERO
   } base_type;

   typedef enum logic [1:0] {
      SH_NONE, SH_GUARD, SH_YHIGH
   } shift_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_Y, CAP_Z1, CAP_Z2, CAP_OUT
   } cap_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_SKIP, JMP_END
   } jump_type;

   typedef struct packed {
      mul_a_type            mul_a;
      mul_b_type            mul_b;
      base_type             base;
      logic                 add_en;
      logic                 add_neg;
      shift_type            shift;
      cap_type              cap;
      jump_type             jump;
      logic [PC_BITS-1:0]   target;
   } ctl_type;

   // Writes into the delay state store.
   typedef struct packed {
      logic wr_en;
      logic kill_en;
      logic clear_all;
   } st_ctl_type;

   localparam logic [PC_BITS-1:0] STEP_OUT = 4'd13;

   function automatic ctl_type uw(mul_a_type ma, mul_b_type mb, base_type bs, logic en,
                                  logic ng, shift_type sh, cap_type cp, jump_type jp,
                                  logic [PC_BITS-1:0] tg);
      ctl_type w;
      w.mul_a   = ma;
      w.mul_b   = mb;
      w.base    = bs;
      w.add_en  = en;
      w.add_neg = ng;
      w.shift   = sh;
      w.cap     = cp;
      w.jump    = jp;
      w.target  = tg;
      return w;
   endfunction

   // Microprogram. The multiplier product issued in one step is added in the next.
   // y = b0*x + z1; z1' = b1*x - a1*y + z2; z2' = b2*x - a2*y; out = dry*x + wet*y.
   function automatic ctl_type ucode(logic [PC_BITS-1:0] pc);
      ctl_type w;
      case (pc)
         4'd0:  w = uw(MA_B0,  MB_X,  BASE_ACC,  1'b0, 1'b0, SH_NONE,  CAP_NONE, JMP_SKIP,
                       STEP_OUT);
         4'd1:  w = uw(MA_B1,  MB_X,  BASE_Z1,   1'b1, 1'b0, SH_GUARD, CAP_NONE, JMP_NEXT, '0);
         4'd2:  w = uw(MA_B1,  MB_X,  BASE_ACC,  1'b0, 1'b0, SH_NONE,  CAP_Y,    JMP_NEXT, '0);
         4'd3:  w = uw(MA_A1,  MB_YH, BASE_Z2,   1'b1, 1'b0, SH_GUARD, CAP_NONE, JMP_NEXT, '0);
         4'd4:  w = uw(MA_A1,  MB_YL, BASE_ACC,  1'b1, 1'b1, SH_YHIGH, CAP_NONE, JMP_NEXT, '0);
         4'd5:  w = uw(MA_B2,  MB_X,  BASE_ACC,  1'b1, 1'b1, SH_NONE,  CAP_NONE, JMP_NEXT, '0);
         4'd6:  w = uw(MA_A2,  MB_YH, BASE_ZERO, 1'b1, 1'b0, SH_GUARD, CAP_Z1,   JMP_NEXT, '0);
         4'd7:  w = uw(MA_A2,  MB_YL, BASE_ACC,  1'b1, 1'b1, SH_YHIGH, CAP_NONE, JMP_NEXT, '0);
         4'd8:  w = uw(MA_DRY, MB_X,  BASE_ACC,  1'b1, 1'b1, SH_NONE,  CAP_NONE, JMP_NEXT, '0);
         4'd9:  w = uw(MA_DRY, MB_X,  BASE_ZERO, 1'b1, 1'b0, SH_GUARD, CAP_Z2,   JMP_NEXT, '0);
         4'd10: w = uw(MA_WET, MB_YH, BASE_ACC,  1'b0, 1'b0, SH_NONE,  CAP_NONE, JMP_NEXT, '0);
         4'd11: w = uw(MA_WET, MB_YL, BASE_ACC,  1'b1, 1'b0, SH_YHIGH, CAP_NONE, JMP_NEXT, '0);
         4'd12: w = uw(MA_WET, MB_YL, BASE_ACC,  1'b1, 1'b0, SH_NONE,  CAP_NONE, JMP_NEXT, '0);
         4'd13: w = uw(MA_WET, MB_YL, BASE_ACC,  1'b0, 1'b0, SH_NONE,  CAP_OUT,  JMP_END,  '0);
         default: w = uw(MA_WET, MB_YL, BASE_ACC, 1'b0, 1'b0, SH_NONE, CAP_NONE, JMP_END, '0);
      endcase
      return w;
   endfunction

   // Word driven while the sequencer is idle: holds everything.
   localparam ctl_type CTL_IDLE = uw(MA_WET, MB_YL, BASE_ACC, 1'b0, 1'b0, SH_NONE, CAP_NONE,
                                     JMP_END, 4'd0);

endpackage

// ===== hdl/bqf_sequencer.sv =====
`timescale 1ns / 1ps

module bqf_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              skip,
   input  logic              out_free,
   output bqf_pkg::ctl_type  ctl,
   output logic              busy,
   output logic              done
);
   import bqf_pkg::*;

   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic               busy_ff, busy_in;
   ctl_type            word;

   assign word = ucode(pc_ff);
   assign ctl  = busy_ff ? word : CTL_IDLE;
   assign busy = busy_ff;

   // Step counter with a conditional jump and a final step that waits for the output slot.
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      done    = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else begin
         case (word.jump)
            JMP_NEXT: pc_in = pc_ff + PC_BITS'(1);
            JMP_SKIP: pc_in = skip ? word.target : pc_ff + PC_BITS'(1);
            JMP_END: begin
               if (out_free) begin
                  done    = 1'b1;
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hdl/bqf_datapath.sv =====
`timescale 1ns / 1ps

module bqf_datapath #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 27
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bqf_pkg::ctl_type                       ctl,
   input  bqf_pkg::cfg_type                       cfg,
   input  logic signed [SAMPLE_BITS-1:0]          x,
   input  logic signed [bqf_pkg::STATE_BITS-1:0]  z1_rd,
   input  logic signed [bqf_pkg::STATE_BITS-1:0]  z2_rd,
   output logic signed [bqf_pkg::STATE_BITS-1:0]  z1_new,
   output logic signed [bqf_pkg::STATE_BITS-1:0]  z2_new,
   output logic                                   ovf,
   output logic signed [SAMPLE_BITS-1:0]          mix_sat
);
   import bqf_pkg::*;

   localparam int MB_BITS   = (SAMPLE_BITS > Y_LOW_BITS + 1) ? SAMPLE_BITS : Y_LOW_BITS + 1;
   localparam int PROD_BITS = COEF_BITS + MB_BITS;
   localparam int ACC_BITS  = ((PROD_BITS + Y_LOW_BITS > STATE_BITS + COEF_FRAC_BITS) ?
                               PROD_BITS + Y_LOW_BITS : STATE_BITS + COEF_FRAC_BITS) + 3;

   logic signed [COEF_BITS-1:0]  mul_a;
   logic signed [MB_BITS-1:0]    mul_b;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in, base, addend;
   logic signed [ACC_BITS-1:0]   rnd_c, rnd_m;
   logic signed [STATE_BITS-1:0] y_ff, y_op, z1_ff, z2_ff;
   logic                         ovf_ff;
   logic                         fits_c, fits_m;

   // A channel that overflowed anywhere contributes y = 0 for the rest of that item.
   assign y_op = ovf_ff ? '0 : y_ff;

   // Shared multiplier operands; y is split into a signed high and unsigned low half.
   always_comb begin
      case (ctl.mul_a)
         MA_B0:   mul_a = cfg.b0;
         MA_B1:   mul_a = cfg.b1;
         MA_B2:   mul_a = cfg.b2;
         MA_A1:   mul_a = cfg.a1;
         MA_A2:   mul_a = cfg.a2;
         MA_WET:  mul_a = COEF_BITS'({1'b0, cfg.wet});
         MA_DRY:  mul_a = COEF_BITS'({1'b0, cfg.dry});
         default: mul_a = '0;
      endcase
      case (ctl.mul_b)
         MB_X:    mul_b = MB_BITS'(x);
         MB_YH:   mul_b = MB_BITS'($signed(y_op[STATE_BITS-1:Y_LOW_BITS]));
         MB_YL:   mul_b = MB_BITS'({1'b0, y_op[Y_LOW_BITS-1:0]});
         default: mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Accumulator: a base term, alone or plus or minus the aligned product of the previous step.
   always_comb begin
      case (ctl.base)
         BASE_ACC:  base = acc_ff;
         BASE_Z1:   base = ACC_BITS'(z1_rd) <<< COEF_FRAC_BITS;
         BASE_Z2:   base = ACC_BITS'(z2_rd) <<< COEF_FRAC_BITS;
         BASE_ZERO: base = '0;
         default:   base = '0;
      endcase
      case (ctl.shift)
         SH_NONE:  addend = ACC_BITS'(prod_ff);
         SH_GUARD: addend = ACC_BITS'(prod_ff) <<< GUARD_BITS;
         SH_YHIGH: addend = ACC_BITS'(prod_ff) <<< Y_LOW_BITS;
         default:  addend = '0;
      endcase
      if (!ctl.add_en) begin
         acc_in = base;
      end else if (ctl.add_neg) begin
         acc_in = base - addend;
      end else begin
         acc_in = base + addend;
      end
   end

   // Round half up for the filter states and for the mix.
   assign rnd_c  = (acc_ff + (ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   assign rnd_m  = (acc_ff + (ACC_BITS'(1) <<< (MIX_SHIFT - 1))) >>> MIX_SHIFT;
   assign fits_c = (&rnd_c[ACC_BITS-1:STATE_BITS-1]) || !(|rnd_c[ACC_BITS-1:STATE_BITS-1]);
   assign fits_m = (&rnd_m[ACC_BITS-1:SAMPLE_BITS-1]) || !(|rnd_m[ACC_BITS-1:SAMPLE_BITS-1]);

   always_comb begin
      if (fits_m) begin
         mix_sat = rnd_m[SAMPLE_BITS-1:0];
      end else if (rnd_m[ACC_BITS-1]) begin
         mix_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         mix_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end
   end

   assign z1_new = z1_ff;
   assign z2_new = z2_ff;
   assign ovf    = ovf_ff;

   // Product and accumulator registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Captured results of the recursion.
   always_ff @(posedge clock) begin
      case (ctl.cap)
         CAP_Y:   y_ff  <= fits_c ? rnd_c[STATE_BITS-1:0] : '0;
         CAP_Z1:  z1_ff <= rnd_c[STATE_BITS-1:0];
         CAP_Z2:  z2_ff <= rnd_c[STATE_BITS-1:0];
         default: ;
      endcase
   end

   // Overflow flag restarts at the y capture and collects the two state captures.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff <= 1'b0;
      end else begin
         case (ctl.cap)
            CAP_Y:   ovf_ff <= !fits_c;
            CAP_Z1:  ovf_ff <= ovf_ff || !fits_c;
            CAP_Z2:  ovf_ff <= ovf_ff || !fits_c;
            default: ;
         endcase
      end
   end

endmodule

// ===== hdl/bqf_state_mem.sv =====
`timescale 1ns / 1ps

module bqf_state_mem #(
   parameter int DEPTH     = 8,
   parameter int ADDR_BITS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bqf_pkg::st_ctl_type                    st_ctl,
   input  logic [ADDR_BITS-1:0]                   addr,
   input  logic signed [bqf_pkg::STATE_BITS-1:0]  z1_wr,
   input  logic signed [bqf_pkg::STATE_BITS-1:0]  z2_wr,
   output logic signed [bqf_pkg::STATE_BITS-1:0]  z1_rd,
   output logic signed [bqf_pkg::STATE_BITS-1:0]  z2_rd
);
   import bqf_pkg::*;

   logic signed [STATE_BITS-1:0] z1_mem [DEPTH];
   logic signed [STATE_BITS-1:0] z2_mem [DEPTH];
   logic signed [STATE_BITS-1:0] z1_rd_ff, z2_rd_ff;
   logic [DEPTH-1:0]             valid_ff;
   logic                         rd_valid_ff;

   // Delay states, written at the end of an item and read with a registered port.
   always_ff @(posedge clock) begin
      if (st_ctl.wr_en) begin
         z1_mem[addr] <= z1_wr;
         z2_mem[addr] <= z2_wr;
      end
      z1_rd_ff <= z1_mem[addr];
      z2_rd_ff <= z2_mem[addr];
   end

   // One valid bit per channel; a channel that is not valid reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[addr];
         if (st_ctl.clear_all) begin
            valid_ff <= '0;
         end else if (st_ctl.wr_en) begin
            valid_ff[addr] <= 1'b1;
         end else if (st_ctl.kill_en) begin
            valid_ff[addr] <= 1'b0;
         end
      end
   end

   assign z1_rd = rd_valid_ff ? z1_rd_ff : '0;
   assign z2_rd = rd_valid_ff ? z2_rd_ff : '0;

endmodule

// ===== hdl/biquad_tdf2_wet_dry_filter_core.sv =====
`timescale 1ns / 1ps

// Multi-channel biquad filter (transposed direct form II) with a wet/dry mix.
// Input channel req_*: one interleaved sample with its channel number, a silent
// flag and a bypass flag in tuser, and tlast on the last sample of a block.
// Result channel rsp_*: the mixed, saturated sample with its channel number;
// tuser carries the block silence flag and tlast repeats the input's block end.
// Configuration channel csr_*: coefficients, gains and the channel count, to be written by the
// user only while no item is in flight; the block itself does not enforce this; csr_ready is always high.
// A filtered item runs through a 14-step microprogram on one shared 32 x 25
// multiplier and one accumulator; a bypassed item or one for an unused channel
// jumps from the first step straight to the last. A new item is accepted only
// after the previous one finishes, so items never overlap in the datapath.
// The result sits in an output register; a new item is accepted and computed
// while it waits, and only the last step stalls until the receiver takes it.
// Reset clears all delay states, the silence tracker and loads the default
// registers (unity b0, wet gain one, one channel).
module biquad_tdf2_wet_dry_filter_core #(
   parameter  int MAX_CHANNELS   = 8,
   parameter  int SAMPLE_BITS    = 24,
   parameter  int COEF_FRAC_BITS = 27,
   localparam int CH_BITS        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int REQ_DATA_BITS  = ((CH_BITS + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS  = ((SAMPLE_BITS + CH_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input items.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_DATA_BITS-1:0]              req_tdata,  // channel, sample_in, zero fill
   input  logic [1:0]                            req_tuser,  // input_silent, bypass
   input  logic                                  req_tlast,  // end_of_block
   // Result items.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [RSP_DATA_BITS-1:0]              rsp_tdata,  // sample_out, channel_out, zero fill
   output logic [0:0]                            rsp_tuser,  // block_silent
   output logic                                  rsp_tlast,  // last_of_block
   // Configuration writes.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bqf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bqf_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import bqf_pkg::*;

   localparam int CMP_BITS = (CH_BITS + 1 > CHCOUNT_BITS) ? CH_BITS + 1 : CHCOUNT_BITS;
   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

   cfg_type                      cfg_ff;
   logic [CH_BITS-1:0]           ch_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                         bypass_ff, eob_ff;
   logic                         seen_ff, seen_in;
   logic                         rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [CH_BITS-1:0]           rsp_ch_ff;
   logic                         rsp_silent_ff, rsp_last_ff;

   ctl_type                      ctl;
   st_ctl_type                   st_ctl;
   logic                         busy, done, start, skip, out_free, in_use, csr_wr;
   logic [CMP_BITS-1:0]          active;
   logic signed [SAMPLE_BITS-1:0] mix_sat, res;
   logic signed [STATE_BITS-1:0] z1_rd, z2_rd, z1_new, z2_new;
   logic                         ovf, silent_flag;

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid && csr_ready;
   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.b0       <= COEF_ONE;
         cfg_ff.b1       <= '0;
         cfg_ff.b2       <= '0;
         cfg_ff.a1       <= '0;
         cfg_ff.a2       <= '0;
         cfg_ff.wet      <= WET_RESET;
         cfg_ff.dry      <= DRY_RESET;
         cfg_ff.channels <= CHCOUNT_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            REG_COEF_B0:  cfg_ff.b0       <= csr_data;
            REG_COEF_B1:  cfg_ff.b1       <= csr_data;
            REG_COEF_B2:  cfg_ff.b2       <= csr_data;
            REG_COEF_A1:  cfg_ff.a1       <= csr_data;
            REG_COEF_A2:  cfg_ff.a2       <= csr_data;
            REG_WET_GAIN: cfg_ff.wet      <= csr_data[GAIN_BITS-1:0];
            REG_DRY_GAIN: cfg_ff.dry      <= csr_data[GAIN_BITS-1:0];
            REG_CHANNELS: cfg_ff.channels <= csr_data[CHCOUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Channel count clamped to the range of the state store; zero acts as one.
   always_comb begin
      if (cfg_ff.channels == '0) begin
         active = CMP_BITS'(1);
      end else if (CMP_BITS'(cfg_ff.channels) > CMP_BITS'(MAX_CHANNELS)) begin
         active = CMP_BITS'(MAX_CHANNELS);
      end else begin
         active = CMP_BITS'(cfg_ff.channels);
      end
   end

   assign in_use = CMP_BITS'(ch_ff) < active;
   assign skip   = bypass_ff || !in_use;

   // Input item registers; a silent sample enters as zero.
   always_ff @(posedge clock) begin
      if (start) begin
         ch_ff     <= req_tdata[CH_BITS-1:0];
         x_ff      <= req_tuser[0] ? '0 : req_tdata[CH_BITS+SAMPLE_BITS-1:CH_BITS];
         bypass_ff <= req_tuser[1];
         eob_ff    <= req_tlast;
      end
   end

   bqf_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .skip     (skip),
      .out_free (out_free),
      .ctl      (ctl),
      .busy     (busy),
      .done     (done)
   );

   bqf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .cfg     (cfg_ff),
      .x       (x_ff),
      .z1_rd   (z1_rd),
      .z2_rd   (z2_rd),
      .z1_new  (z1_new),
      .z2_new  (z2_new),
      .ovf     (ovf),
      .mix_sat (mix_sat)
   );

   // Filtered item end: write states, or clear on overflow; bypass or a channel count write clears all.
   assign st_ctl.wr_en     = done && !skip && !ovf;
   assign st_ctl.kill_en   = done && !skip && ovf;
   assign st_ctl.clear_all = (done && bypass_ff) || (csr_wr && csr_index == REG_CHANNELS);

   bqf_state_mem #(
      .DEPTH     (MAX_CHANNELS),
      .ADDR_BITS (CH_BITS)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .st_ctl (st_ctl),
      .addr   (ch_ff),
      .z1_wr  (z1_new),
      .z2_wr  (z2_new),
      .z1_rd  (z1_rd),
      .z2_rd  (z2_rd)
   );

   // Final sample selection and block silence tracking.
   always_comb begin
      if (bypass_ff) begin
         res = x_ff;
      end else if (!in_use) begin
         res = '0;
      end else begin
         res = mix_sat;
      end
      silent_flag = 1'b0;
      seen_in     = seen_ff;
      if (done) begin
         if (eob_ff) begin
            silent_flag = !(seen_ff || (|res));
            seen_in     = 1'b0;
         end else begin
            seen_in = seen_ff || (|res);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_sample_ff <= res;
         rsp_ch_ff     <= ch_ff;
         rsp_silent_ff <= silent_flag;
         rsp_last_ff   <= eob_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_DATA_BITS'({rsp_ch_ff, rsp_sample_ff});
   assign rsp_tuser[0] = rsp_silent_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule

// ===== hdl/bqf_checker.sv =====
`timescale 1ns / 1ps

module bqf_checker #(
   parameter int SAMPLE_BITS   = 24,
   parameter int RSP_DATA_BITS = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser,
   input logic                     rsp_tlast
);

   // A result that is not taken stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The silence flag only appears on the last item of a block.
   a_silent_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("block silence reported off the block end");

   // A silent block ends with a zero sample.
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[SAMPLE_BITS-1:0] == '0)
      else $error("block reported silent with a nonzero last sample");

   // One item at a time: the input closes right after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in progress");

   // Reset empties the output and opens the input.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output or input not idle after reset");

endmodule

bind biquad_tdf2_wet_dry_filter_core bqf_checker #(
   .SAMPLE_BITS   (SAMPLE_BITS),
   .RSP_DATA_BITS (RSP_DATA_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/biquad_tdf2_wet_dry_filter_core_test.sv =====
`timescale 1ns / 1ps

module biquad_tdf2_wet_dry_filter_core_test;
   import bqf_pkg::*;

   localparam int  NUM_CH        = 8;
   localparam int  COEF_FRAC     = 27;
   localparam int  IDLE_LIMIT    = 3000;
   localparam int  PRESSURE_HOLD = 400;
   localparam int  PHASES        = 11;
   localparam int  PHASE_ITEMS   = 145;

   // Wide signed working type for the filter arithmetic; every product and sum fits.
   typedef logic signed [127:0] acc_type;

   localparam acc_type MIX_MAX = 128'sd8388607;
   localparam acc_type MIX_MIN = -128'sd8388608;

   typedef struct packed {
      logic [23:0] sample;
      logic [2:0]  channel;
      logic        silent;
      logic        last;
   } filter_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   // Shadow copy of the registers and the per-channel delay states.
   logic signed [31:0] cfg_b0, cfg_b1, cfg_b2, cfg_a1, cfg_a2;
   logic [15:0]        cfg_wet, cfg_dry;
   logic [3:0]         cfg_channels;
   logic signed [47:0] z1_state [NUM_CH];
   logic signed [47:0] z2_state [NUM_CH];
   bit                 nonzero_seen;

   filter_result_type expected_results [$];
   int unsigned    error_count;
   int unsigned    idle_cycles;
   int unsigned    rsp_hold_len;
   bit             send_idle_on;
   bit             recv_idle_on;

   biquad_tdf2_wet_dry_filter_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly no gap or a short one, now and then a long one.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Channel count as the block uses it: zero acts as one, large values clamp.
   function automatic int unsigned in_use_count();
      if (cfg_channels == 0) return 1;
      if (cfg_channels > NUM_CH) return NUM_CH;
      return cfg_channels;
   endfunction

   // Right shift with round half up.
   function automatic acc_type round_shift(acc_type v, int s);
      acc_type half;
      half = 1;
      half = half <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic bit fits_state(acc_type v);
      acc_type lim;
      lim = 1;
      lim = lim <<< (STATE_BITS - 1);
      return (v >= -lim) && (v < lim);
   endfunction

   function automatic void clear_delays();
      foreach (z1_state[i]) begin
         z1_state[i] = '0;
         z2_state[i] = '0;
      end
   endfunction

   // Filters one item through the shadow state and returns the mixed output.
   function automatic filter_result_type filter_predict(logic [2:0] ch,
                                                        logic signed [23:0] smp,
                                                        bit silent, bit bypass, bit eob);
      acc_type x, y, t, z1n, z2n, mixv, res;
      acc_type b0, b1, b2, a1, a2, wet, dry, d1, d2;
      bit ok;
      filter_result_type r;
      x = 0;
      if (!silent) x = smp;
      res = 0;
      if (bypass) begin
         clear_delays();
         res = x;
      end else if (ch < in_use_count()) begin
         b0  = cfg_b0;
         b1  = cfg_b1;
         b2  = cfg_b2;
         a1  = cfg_a1;
         a2  = cfg_a2;
         wet = cfg_wet;
         dry = cfg_dry;
         d1  = z1_state[ch];
         d2  = z2_state[ch];
         ok  = 1'b0;
         y   = 0;
         t = round_shift(((b0 * x) <<< GUARD_BITS) + (d1 <<< COEF_FRAC), COEF_FRAC);
         if (fits_state(t)) begin
            y   = t;
            z1n = round_shift(((b1 * x) <<< GUARD_BITS) - a1 * y + (d2 <<< COEF_FRAC),
                              COEF_FRAC);
            z2n = round_shift(((b2 * x) <<< GUARD_BITS) - a2 * y, COEF_FRAC);
            ok  = fits_state(z1n) && fits_state(z2n);
         end
         // An overflow anywhere clears this channel and mutes the filtered path.
         if (ok) begin
            z1_state[ch] = z1n[47:0];
            z2_state[ch] = z2n[47:0];
         end else begin
            z1_state[ch] = '0;
            z2_state[ch] = '0;
            y = 0;
         end
         mixv = round_shift(((x * dry) <<< GUARD_BITS) + y * wet, MIX_SHIFT);
         if (mixv > MIX_MAX) res = MIX_MAX;
         else if (mixv < MIX_MIN) res = MIX_MIN;
         else res = mixv;
      end
      if (res != 0) nonzero_seen = 1'b1;
      r.silent = 1'b0;
      if (eob) begin
         r.silent = !nonzero_seen;
         nonzero_seen = 1'b0;
      end
      r.sample  = res[23:0];
      r.channel = ch;
      r.last    = eob;
      return r;
   endfunction

   // Offers one item, waits for it to be taken and records what it should produce.
   // The valid stays high on return so that back-to-back items can follow without a gap.
   task automatic send_sample(logic [2:0] ch, logic signed [23:0] smp, bit silent,
                              bit bypass, bit eob);
      int unsigned gap;
      gap = send_idle_on ? gap_len() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b00000, smp, ch};
      req_tuser  <= {bypass, silent};
      req_tlast  <= eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(filter_predict(ch, smp, silent, bypass, eob));
   endtask

   // Writes one register; the caller lowers csr_valid after its last write.
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_COEF_B0:  cfg_b0 = value;
         REG_COEF_B1:  cfg_b1 = value;
         REG_COEF_B2:  cfg_b2 = value;
         REG_COEF_A1:  cfg_a1 = value;
         REG_COEF_A2:  cfg_a2 = value;
         REG_WET_GAIN: cfg_wet = value[15:0];
         REG_DRY_GAIN: cfg_dry = value[15:0];
         REG_CHANNELS: begin
            cfg_channels = value[3:0];
            clear_delays();
         end
         default: ;
      endcase
   endtask

   // Stops offering items and waits until every outstanding result has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Reset settings: unity pass-through on channel 0, unused channels, bypass, silence.
   task automatic test_defaults();
      send_sample(3'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0);
      send_sample(3'd0, 24'h800000, 1'b0, 1'b0, 1'b0);
      send_sample(3'd0, 24'h000000, 1'b0, 1'b0, 1'b1);
      send_sample(3'd0, 24'h123456, 1'b1, 1'b0, 1'b1);
      send_sample(3'd1, 24'h7FFFFF, 1'b0, 1'b0, 1'b1);
      send_sample(3'd7, 24'hFFFFFF, 1'b0, 1'b0, 1'b0);
      send_sample(3'd0, 24'hFFFFFF, 1'b0, 1'b1, 1'b0);
      send_sample(3'd0, 24'h7FFFFF, 1'b1, 1'b1, 1'b1);
   endtask

   // Extreme coefficients and gains: the states blow up and the mix saturates.
   task automatic test_overflow();
      wait_idle();
      write_reg(REG_COEF_B0, 32'h7FFFFFFF);
      write_reg(REG_COEF_B1, 32'h7FFFFFFF);
      write_reg(REG_COEF_B2, 32'h80000000);
      write_reg(REG_COEF_A1, 32'h80000000);
      write_reg(REG_COEF_A2, 32'h7FFFFFFF);
      write_reg(REG_WET_GAIN, 32'h0000FFFF);
      write_reg(REG_DRY_GAIN, 32'h0000FFFF);
      write_reg(REG_CHANNELS, 32'h0000000F);
      csr_valid <= 1'b0;
      repeat (4) send_sample(3'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0);
      repeat (3) send_sample(3'd5, 24'h800000, 1'b0, 1'b0, 1'b0);
      send_sample(3'd7, 24'h7FFFFF, 1'b0, 1'b0, 1'b1);
   endtask

   // A channel count of zero behaves as one; bypass wipes the states of all channels.
   task automatic test_channel_count_zero();
      wait_idle();
      write_reg(REG_CHANNELS, 32'h00000000);
      write_reg(REG_WET_GAIN, 32'h00000000);
      write_reg(REG_DRY_GAIN, 32'h00008000);
      csr_valid <= 1'b0;
      send_sample(3'd0, 24'h400000, 1'b0, 1'b0, 1'b0);
      send_sample(3'd1, 24'h400000, 1'b0, 1'b0, 1'b0);
      send_sample(3'd0, 24'h000001, 1'b1, 1'b0, 1'b1);
      send_sample(3'd1, 24'h2AAAAA, 1'b0, 1'b1, 1'b0);
      send_sample(3'd0, 24'h555555, 1'b0, 1'b0, 1'b1);
   endtask

   // The receiver stops for a long stretch while items keep coming, so the input stalls.
   task automatic test_backpressure();
      wait_idle();
      write_reg(REG_COEF_B0, 32'h08000000);
      write_reg(REG_COEF_A1, 32'hF8000000);
      write_reg(REG_WET_GAIN, 32'h00008000);
      write_reg(REG_CHANNELS, 32'h00000004);
      csr_valid <= 1'b0;
      send_idle_on = 1'b0;
      rsp_hold_len = PRESSURE_HOLD;
      for (int i = 0; i < 30; i++)
         send_sample(3'(i % 4), 24'($urandom), 1'b0, 1'b0, (i % 10) == 9);
      send_idle_on = 1'b1;
   endtask

   // Random settings per phase, then blocks of interleaved samples on the channels in use.
   task automatic test_random_blocks();
      int          cb0, cb1, cb2, ca1, ca2, lim;
      int unsigned blen, sent, r, nch;
      bit          quiet_block;
      logic [2:0]  ch;
      logic signed [23:0] smp;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         if ($urandom_range(0, 6) == 0) begin
            cb0 = $urandom;
            cb1 = $urandom;
            cb2 = $urandom;
            ca1 = $urandom;
            ca2 = $urandom;
         end else begin
            // Stable pole pair: |a2| below one and |a1| below one plus a2.
            ca2 = int'($urandom_range(0, 255013682)) - 127506841;
            lim = ((134217728 + ca2) / 20) * 19;
            ca1 = int'($urandom_range(0, 2 * lim)) - lim;
            cb0 = int'($urandom_range(0, 268435456)) - 134217728;
            cb1 = int'($urandom_range(0, 268435456)) - 134217728;
            cb2 = int'($urandom_range(0, 268435456)) - 134217728;
         end
         write_reg(REG_COEF_B0, cb0);
         write_reg(REG_COEF_B1, cb1);
         write_reg(REG_COEF_B2, cb2);
         write_reg(REG_COEF_A1, ca1);
         write_reg(REG_COEF_A2, ca2);
         write_reg(REG_WET_GAIN, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 32768));
         write_reg(REG_DRY_GAIN, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 32768));
         if (phase == 0 || $urandom_range(0, 1) == 1)
            write_reg(REG_CHANNELS, ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(1, 8));
         csr_valid <= 1'b0;
         send_idle_on = (phase % 3) != 0;
         recv_idle_on = (phase % 4) != 1;
         nch = in_use_count();
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            blen = $urandom_range(1, 16);
            quiet_block = $urandom_range(0, 7) == 0;
            for (int i = 0; i < blen; i++) begin
               if ($urandom_range(0, 6) == 0) ch = 3'($urandom_range(0, 7));
               else ch = 3'($urandom_range(0, nch - 1));
               r = $urandom_range(0, 9);
               if (r < 7) smp = 24'($urandom);
               else if (r < 9) smp = 24'(int'($urandom_range(0, 8192)) - 4096);
               else begin
                  case ($urandom_range(0, 3))
                     0: smp = 24'h7FFFFF;
                     1: smp = 24'h800000;
                     2: smp = 24'hFFFFFF;
                     default: smp = 24'h000000;
                  endcase
               end
               send_sample(ch, smp, quiet_block || $urandom_range(0, 19) == 0,
                           $urandom_range(0, 49) == 0, i == blen - 1);
               sent++;
            end
         end
      end
   endtask

   // Compares every accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      filter_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result item, got %h", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[23:0] !== want.sample) begin
               error_count++;
               $display("%0t: sample_out expected %h got %h", $time, want.sample,
                        rsp_tdata[23:0]);
            end
            if (rsp_tdata[26:24] !== want.channel) begin
               error_count++;
               $display("%0t: channel_out expected %0d got %0d", $time, want.channel,
                        rsp_tdata[26:24]);
            end
            if (rsp_tuser[0] !== want.silent) begin
               error_count++;
               $display("%0t: block_silent expected %b got %b", $time, want.silent,
                        rsp_tuser[0]);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: last_of_block expected %b got %b", $time, want.last,
                        rsp_tlast);
            end
         end
      end
   end

   // Result side: random stalls, or one long hold-off when asked for.
   initial begin : rsp_receiver
      int unsigned n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_len != 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len() + 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Ends the run when no item moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= '0;
      req_tlast    <= 1'b0;
      csr_valid    <= 1'b0;
      csr_index    <= REG_COEF_B0;
      csr_data     <= '0;
      idle_cycles  = 0;
      error_count  = 0;
      rsp_hold_len = 0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      // Register values and states after reset.
      cfg_b0       = 32'sd134217728;
      cfg_b1       = '0;
      cfg_b2       = '0;
      cfg_a1       = '0;
      cfg_a2       = '0;
      cfg_wet      = WET_RESET;
      cfg_dry      = DRY_RESET;
      cfg_channels = CHCOUNT_RESET;
      nonzero_seen = 1'b0;
      clear_delays();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_overflow();
      test_channel_count_zero();
      test_backpressure();
      test_random_blocks();

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
